>>> rtl/assert_macros.svh
// Assertion macros used by the trie walk sequencer of the domain trie matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Clocked property that must also hold through reset.
`define ASSERT_NOW(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NOW(lbl, clk, prop)
`endif
`endif

>>> rtl/dtm_pkg.sv
// Types, constants and the symbol decoder of the domain trie matcher.
package dtm_pkg;

  localparam int NODES    = 16384;
  localparam int ALPHABET = 38;

  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int FREE_W = $clog2(NODES + 1);
  localparam int SYM_W  = 6;
  // One row per node: a child pointer per symbol, end mark on top.
  localparam int END_BIT = ALPHABET * NODE_W;
  localparam int ROW_W   = END_BIT + 1;

  localparam int SYM_LETTER_BASE = 10;
  localparam int SYM_DOT         = 36;
  localparam int SYM_HYPHEN      = 37;

  localparam logic [FREE_W-1:0] NODES_F = FREE_W'(NODES);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] code;
  } sym_t;

  typedef struct packed {
    logic             op;
    logic             sym_ok;
    logic [SYM_W-1:0] sym;
    logic             has_ch;
    logic             last;
  } item_t;

  typedef struct packed {
    logic vld;
    logic found;
    logic full;
  } res_t;

  // Map a key byte onto the alphabet; letters fold to one case.
  function automatic sym_t symbol_of(input logic [7:0] ch);
    sym_t s;
    s.ok   = 1'b1;
    s.code = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      s.code = SYM_W'(ch - 8'h30);
    end else if (ch >= 8'h41 && ch <= 8'h5a) begin
      s.code = SYM_W'(ch - 8'h41 + 8'(SYM_LETTER_BASE));
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      s.code = SYM_W'(ch - 8'h61 + 8'(SYM_LETTER_BASE));
    end else if (ch == 8'h2e) begin
      s.code = SYM_W'(SYM_DOT);
    end else if (ch == 8'h2d) begin
      s.code = SYM_W'(SYM_HYPHEN);
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> rtl/dtm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/dtm_walk.sv
// Trie walk sequencer: read-modify-write of node rows, allocation and end marks.
`include "assert_macros.svh"
module dtm_walk (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_valid,
  output logic            item_ready,
  input  dtm_pkg::item_t  item,
  output dtm_pkg::res_t   res,
  input  logic            res_ready,
  output logic            rd_en,
  output dtm_pkg::node_t  rd_addr,
  input  dtm_pkg::row_t   rd_data,
  output logic            wr_en,
  output dtm_pkg::node_t  wr_addr,
  output dtm_pkg::row_t   wr_data
);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_STEP, S_END, S_CLR} state_t;

  state_t                       state_r, state_nxt;
  dtm_pkg::item_t               item_r, item_nxt;
  dtm_pkg::node_t               cursor_r, cursor_nxt;
  logic                         miss_r, miss_nxt;
  logic [dtm_pkg::FREE_W-1:0]   next_free_r, next_free_nxt;

  dtm_pkg::node_t               child;
  logic                         walk, moved, alloc;
  logic                         do_end, end_miss;
  dtm_pkg::row_t                end_row;
  logic [dtm_pkg::FREE_W-1:0]   cursor_ext, wr_addr_ext;

  assign child       = rd_data[item_r.sym * dtm_pkg::NODE_W +: dtm_pkg::NODE_W];
  assign cursor_ext  = {1'b0, cursor_r};
  assign wr_addr_ext = {1'b0, wr_addr};

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cursor_nxt    = cursor_r;
    miss_nxt      = miss_r;
    next_free_nxt = next_free_r;
    item_ready    = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cursor_r;
    wr_en         = 1'b0;
    wr_addr       = cursor_r;
    wr_data       = rd_data;
    res           = '0;
    walk          = item_r.has_ch && !miss_r;
    moved         = 1'b0;
    alloc         = 1'b0;
    do_end        = 1'b0;
    end_miss      = miss_r;
    end_row       = rd_data;

    case (state_r)
      S_INIT: begin
        // Clear the root row; every other row is cleared when allocated.
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = '0;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt  = item;
          rd_en     = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (walk) begin
          if (item_r.op == dtm_pkg::OP_INSERT) begin
            if (item_r.sym_ok) begin
              if (child != '0) begin
                moved = 1'b1;
              end else if (next_free_r == dtm_pkg::NODES_F) begin
                end_miss = 1'b1;
              end else begin
                alloc = 1'b1;
              end
            end
          end else begin
            if (!item_r.sym_ok || child == '0) begin
              end_miss = 1'b1;
            end else begin
              moved = 1'b1;
            end
          end
        end
        if (alloc) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          wr_data[item_r.sym * dtm_pkg::NODE_W +: dtm_pkg::NODE_W] =
            next_free_r[dtm_pkg::NODE_W-1:0];
          cursor_nxt    = next_free_r[dtm_pkg::NODE_W-1:0];
          next_free_nxt = next_free_r + 1'b1;
          state_nxt     = S_CLR;
        end else if (moved) begin
          cursor_nxt = child;
          if (item_r.last) begin
            rd_en     = 1'b1;
            rd_addr   = child;
            state_nxt = S_END;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (!item_r.last) begin
          miss_nxt  = end_miss;
          state_nxt = S_IDLE;
        end else begin
          do_end = res_ready;
        end
      end
      S_END: begin
        do_end = res_ready;
      end
      S_CLR: begin
        // Fresh node: no children, end mark only on the last item of the key.
        if (!item_r.last || res_ready) begin
          wr_en     = 1'b1;
          wr_data   = '0;
          wr_data[dtm_pkg::END_BIT] = item_r.last;
          state_nxt = S_IDLE;
          if (item_r.last) begin
            res.vld    = 1'b1;
            cursor_nxt = '0;
            miss_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Close the key at the node reached: mark or test its end bit, or report a full pool.
    if (do_end) begin
      res.vld = 1'b1;
      if (item_r.op == dtm_pkg::OP_INSERT) begin
        res.full = end_miss;
        if (!end_miss) begin
          wr_en   = 1'b1;
          wr_data = end_row;
          wr_data[dtm_pkg::END_BIT] = 1'b1;
        end
      end else begin
        res.found = !end_miss && end_row[dtm_pkg::END_BIT];
      end
      cursor_nxt = '0;
      miss_nxt   = 1'b0;
      state_nxt  = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cursor_r    <= '0;
      miss_r      <= 1'b0;
      next_free_r <= dtm_pkg::FREE_W'(1);
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      miss_r      <= miss_nxt;
      next_free_r <= next_free_nxt;
    end
    item_r <= item_nxt;
  end

  `ASSERT_CLK(a_pool_bound, clk, rst_n, (next_free_r != '0) && (next_free_r <= dtm_pkg::NODES_F))
  `ASSERT_CLK(a_cursor_alloc, clk, rst_n, cursor_ext < next_free_r)
  `ASSERT_CLK(a_wr_alloc, clk, rst_n, wr_en |-> (wr_addr_ext < next_free_r))
  `ASSERT_CLK(a_result_home, clk, rst_n, res.vld |=> ((cursor_r == '0) && !miss_r))

endmodule

>>> rtl/domain_trie_matcher_top.sv
// Top level of the domain trie matcher: stream ports, symbol decode, result register.
// Per key character: the node row is read, then the step is taken; an allocation
//   adds the parent write and then the clear of the new row, and a last item that moves
//   the walk adds a read of the reached row. The result is then registered on out_.
// Items are taken one at a time; a last item also waits for a free result register.
// Reset: synchronous, active low; afterwards the init state clears the root row, then
//   the pool holds only the root and in_tready rises.
module domain_trie_matcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [7:0] character, [8] has_character, [15:9] zero
  input  logic        in_tuser,  // [0] operation
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata  // [0] found, [1] table_full, [7:2] zero
);

  dtm_pkg::sym_t  sym;
  dtm_pkg::item_t item;
  dtm_pkg::res_t  res;
  logic           res_ready;

  logic           rd_en, wr_en;
  dtm_pkg::node_t rd_addr, wr_addr;
  dtm_pkg::row_t  rd_data, wr_data;

  logic           out_valid_r;
  logic [1:0]     out_data_r;

  // Decode the transfer into an alphabet symbol before it enters the walk.
  assign sym         = dtm_pkg::symbol_of(in_tdata[7:0]);
  assign item.op     = in_tuser;
  assign item.sym_ok = sym.ok;
  assign item.sym    = sym.code;
  assign item.has_ch = in_tdata[8];
  assign item.last   = in_tlast;

  // The result register frees itself in the same cycle it is taken.
  assign res_ready = !out_valid_r || out_tready;

  dtm_ram #(
    .WIDTH (dtm_pkg::ROW_W),
    .DEPTH (dtm_pkg::NODES)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dtm_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .res        (res),
    .res_ready  (res_ready),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // Hold the result until the downstream side takes the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res.vld) begin
      out_data_r <= {res.full, res.found};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

endmodule

>>> bench/testbench.sv
// Self-checking bench for the domain trie matcher: random keys, long keys, stalls.
module testbench;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int FILL_CHARS    = 384;
  localparam int FILL_KEY_LEN  = 48;
  localparam int POST_FILL     = 100;
  localparam int DRAIN_CYCLES  = 16;
  localparam int SYM_NONE      = -1;
  localparam string KEY_CHARS  = "0123456789abcdefghijklmnopqrstuvwxyz.-";

  // Receiver behaviour, redrawn at random whenever the current run ends.
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSED} rx_mode_t;

  typedef struct {
    logic       op;
    logic [7:0] ch;
    logic       has_ch;
    logic       last;
    logic       hold;    // wait for every outstanding result before this transfer
  } key_item_t;

  typedef struct {
    logic found;
    logic full;
  } key_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  domain_trie_matcher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Stimulus and expectation stores.
  key_item_t   pending_items[$];
  key_result_t expected_results[$];
  string       stored_keys[$];
  logic        hold_next = 1'b0;
  int          counted_items = 0;

  // Bookkeeping shared between driver, monitor and the closing sequence.
  int keys_predicted = 0;
  int results_seen = 0;
  int found_count = 0;
  int full_count = 0;
  int errors = 0;
  int cycle_count = 0;

  // Shadow of the trie: sparse child map keyed by node*ALPHABET+symbol.
  int trie_child [int];
  bit node_end [dtm_pkg::NODES];
  int next_free = 1;
  int walk_node = 0;
  bit walk_miss = 1'b0;

  function automatic int symbol_code(logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return int'(ch) - 'h30;
    if (ch >= 8'h41 && ch <= 8'h5a) return int'(ch) - 'h41 + dtm_pkg::SYM_LETTER_BASE;
    if (ch >= 8'h61 && ch <= 8'h7a) return int'(ch) - 'h61 + dtm_pkg::SYM_LETTER_BASE;
    if (ch == 8'h2e) return dtm_pkg::SYM_DOT;
    if (ch == 8'h2d) return dtm_pkg::SYM_HYPHEN;
    return SYM_NONE;
  endfunction

  // Advance the shadow walk by one accepted transfer; queue a result on a last item.
  function void predict_key_char(key_item_t it);
    int          sym;
    int          slot;
    key_result_t res;
    sym = symbol_code(it.ch);
    slot = walk_node * dtm_pkg::ALPHABET + sym;
    if (it.has_ch) begin
      if (it.op == dtm_pkg::OP_INSERT) begin
        // invalid bytes are skipped; a miss freezes the walk for the rest of the key
        if (sym != SYM_NONE && !walk_miss) begin
          if (trie_child.exists(slot)) begin
            walk_node = trie_child[slot];
          end else if (next_free >= dtm_pkg::NODES) begin
            walk_miss = 1'b1;
          end else begin
            trie_child[slot] = next_free;
            walk_node = next_free;
            next_free++;
          end
        end
      end else if (!walk_miss) begin
        if (sym == SYM_NONE || !trie_child.exists(slot)) begin
          walk_miss = 1'b1;
        end else begin
          walk_node = trie_child[slot];
        end
      end
    end
    if (it.last) begin
      res.found = 1'b0;
      res.full = 1'b0;
      if (it.op == dtm_pkg::OP_INSERT) begin
        if (walk_miss) res.full = 1'b1;
        else node_end[walk_node] = 1'b1;
      end else begin
        res.found = !walk_miss && node_end[walk_node];
      end
      expected_results.insert(expected_results.size(), res);
      keys_predicted++;
      walk_node = 0;
      walk_miss = 1'b0;
    end
  endfunction

  task automatic push_item(logic op, logic [7:0] ch, logic has_ch, logic last);
    key_item_t it;
    it.op = op;
    it.ch = ch;
    it.has_ch = has_ch;
    it.last = last;
    it.hold = hold_next;
    hold_next = 1'b0;
    pending_items.insert(pending_items.size(), it);
    // an item without a character that does not close a key changes nothing
    if (has_ch || last) counted_items++;
  endtask

  function automatic logic [7:0] invalid_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (symbol_code(b) != SYM_NONE);
    return b;
  endfunction

  // Send a key; noise slips in bare items and, on insert, bytes that get skipped.
  task automatic push_key(logic op, string s, int noise_pct);
    if (s.len() == 0) begin
      push_item(op, 8'($urandom_range(255)), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < s.len(); i++) begin
      if (int'($urandom_range(99)) < noise_pct) begin
        if (op == dtm_pkg::OP_INSERT && $urandom_range(1))
          push_item(op, invalid_byte(), 1'b1, 1'b0);
        else push_item(op, 8'($urandom_range(255)), 1'b0, 1'b0);
      end
      push_item(op, s[i], 1'b1, i == s.len() - 1);
    end
  endtask

  function automatic string random_name(int len);
    string   s;
    logic [7:0] c;
    s = "";
    for (int i = 0; i < len; i++) begin
      c = KEY_CHARS[$urandom_range(dtm_pkg::ALPHABET - 1)];
      if (c >= 8'h61 && $urandom_range(1)) c = c ^ 8'h20;
      s = $sformatf("%s%c", s, c);
    end
    return s;
  endfunction

  // Flip the case of random letters; a hit must not depend on case.
  function automatic string scramble_case(string s);
    string r;
    logic [7:0] c;
    r = s;
    for (int i = 0; i < r.len(); i++) begin
      c = r[i];
      if (((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) && $urandom_range(1))
        r.putc(i, c ^ 8'h20);
    end
    return r;
  endfunction

  function automatic string pick_stored();
    return stored_keys[$urandom_range(stored_keys.size() - 1)];
  endfunction

  function automatic int random_len();
    return ($urandom_range(3) == 0) ? $urandom_range(1, 24) : $urandom_range(0, 6);
  endfunction

  // Mostly well-formed inserts and searches of stored keys, the rest noise.
  task automatic random_keys(int upto);
    int    pick;
    int    n;
    string s;
    while (counted_items < upto) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        s = random_name(random_len());
        push_key(dtm_pkg::OP_INSERT, s, 10);
        stored_keys.insert(stored_keys.size(), s);
      end else if (pick < 65) begin
        push_key(dtm_pkg::OP_SEARCH, scramble_case(pick_stored()), 3);
      end else if (pick < 75) begin
        // near miss: a proper prefix or a one-character extension
        s = pick_stored();
        if (s.len() > 1 && $urandom_range(1)) s = s.substr(0, s.len() - 2);
        else s = {s, random_name(1)};
        push_key(dtm_pkg::OP_SEARCH, s, 0);
      end else if (pick < 85) begin
        push_key(dtm_pkg::OP_SEARCH, random_name(random_len()), 5);
      end else if (pick < 92) begin
        push_key(dtm_pkg::OP_INSERT, scramble_case(pick_stored()), 0);
      end else begin
        // raw bytes with the operation chosen per item
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          push_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                    $urandom_range(3) != 0, i == n - 1);
      end
    end
  endtask

  // Driver: bursts of random length separated by random gaps.
  key_item_t drive_item;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin : drive_proc
    logic fire;
    logic nxt_valid;
    fire = in_tvalid && in_tready;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (fire) predict_key_char(drive_item);
      nxt_valid = in_tvalid && !fire;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].hold || keys_predicted == results_seen)) begin
          drive_item = pending_items.pop_front();
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      in_tvalid <= nxt_valid;
      in_tdata  <= {7'd0, drive_item.has_ch, drive_item.ch};
      in_tuser  <= drive_item.op;
      in_tlast  <= drive_item.last;
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(posedge clk) begin : check_proc
    key_result_t exp_r;
    logic        rdy;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, got tdata %02h", $time, out_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[0] !== exp_r.found) begin
          $display("%0t: found mismatch, expected %0b, got %0b", $time, exp_r.found,
                   out_tdata[0]);
          errors++;
        end
        if (out_tdata[1] !== exp_r.full) begin
          $display("%0t: table_full mismatch, expected %0b, got %0b", $time, exp_r.full,
                   out_tdata[1]);
          errors++;
        end
        if (out_tdata[7:2] !== 6'd0) begin
          $display("%0t: padding mismatch, expected 00, got %02h", $time, out_tdata[7:2]);
          errors++;
        end
        if (exp_r.found) found_count++;
        if (exp_r.full) full_count++;
      end
      results_seen <= results_seen + 1;
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(3));
      rx_left = $urandom_range(40, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  rdy = 1'b1;
      RX_LIGHT: rdy = $urandom_range(3) != 0;
      RX_HEAVY: rdy = $urandom_range(3) == 0;
      default:  rdy = cycle_count[3];
    endcase
    out_tready <= rdy;
  end

  // Watchdog.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               keys_predicted - results_seen);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int fill_chars;
    string s;

    // Empty key: miss on the bare root, then store it and hit it.
    push_key(dtm_pkg::OP_SEARCH, "", 0);
    push_key(dtm_pkg::OP_INSERT, "", 0);
    push_key(dtm_pkg::OP_SEARCH, "", 0);
    // Insert with bytes just outside every alphabet range; those are skipped,
    // so the key stored is 09AZaz-. and the trailing 0xff closes it unchanged.
    push_item(dtm_pkg::OP_INSERT, 8'h00, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h30, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h2f, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h39, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h3a, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h40, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h41, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h5a, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h5b, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h60, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h61, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h7a, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h7b, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h2d, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'h2e, 1'b1, 1'b0);
    push_item(dtm_pkg::OP_INSERT, 8'hff, 1'b1, 1'b1);
    stored_keys.insert(stored_keys.size(), "09AZaz-.");
    // Case folded search of the same key: hit.
    push_key(dtm_pkg::OP_SEARCH, "09azAZ-.", 0);

    random_keys(RANDOM_ITEMS);

    // Long fresh keys allocate a run of new nodes; drain first so the phase starts idle.
    hold_next = 1'b1;
    fill_chars = 0;
    while (fill_chars < FILL_CHARS) begin
      s = random_name(FILL_KEY_LEN);
      push_key(dtm_pkg::OP_INSERT, s, 0);
      stored_keys.insert(stored_keys.size(), s);
      fill_chars += FILL_KEY_LEN;
    end

    // Drain again, then the empty key and more mixed traffic over the grown trie.
    hold_next = 1'b1;
    push_key(dtm_pkg::OP_INSERT, "", 0);
    random_keys(counted_items + POST_FILL);
  end

  // Release reset, then wait for the traffic to drain.
  initial begin : closing
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!(pending_items.size() == 0 && !in_tvalid && keys_predicted == results_seen))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("Covered %0d keys over %0d items: %0d hits, %0d refused with the pool full.",
             keys_predicted, counted_items, found_count, full_count);
    $display("Pool reached %0d of %0d nodes; %0d mismatches logged.", next_free,
             dtm_pkg::NODES, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> domain_trie_matcher_top.f
+incdir+rtl
rtl/dtm_pkg.sv
rtl/dtm_ram.sv
rtl/dtm_walk.sv
rtl/domain_trie_matcher_top.sv
bench/testbench.sv
